### rtl/core/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

    // Busy polls allowed before a pending write is dropped
    localparam int TIMEOUT_POLLS_DEFAULT = 32;

    localparam logic [5:0] CONTRAST_RESET = 6'd30;
    localparam logic [5:0] CONTRAST_MIN   = 6'd20;

    localparam logic [3:0] INIT_LEN = 4'd9;

    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int TUSER_OUT_W = 2;

    typedef enum logic [2:0] {
        CMD_POWER_ON  = 3'd0,
        CMD_POWER_OFF = 3'd1,
        CMD_WRITE_CMD = 3'd2,
        CMD_WRITE_DAT = 3'd3,
        CMD_GOTO      = 3'd4,
        CMD_STATUS    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        OP_BUSY_READ = 2'd0,
        OP_WRITE     = 2'd1,
        OP_POWER_ON  = 2'd2,
        OP_ALL_LOW   = 2'd3
    } op_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] value;
        logic [3:0] column;
        logic       row;
    } item_t;

    typedef struct packed {
        logic [1:0] op;
        logic       reg_select;
        logic [7:0] bus_data;
        logic       timed_out;
        logic       rejected;
        logic       last;
    } result_t;

    // Nine-command init; contrast bits merged into steps three and five
    function automatic logic [7:0] init_cmd(input logic [3:0] step, input logic [5:0] contrast);
        logic [7:0] cmd;
        begin
            unique case (step)
                4'd1:    cmd = 8'h39;
                4'd2:    cmd = 8'h14;
                4'd3:    cmd = 8'h54 | {6'd0, contrast[5:4]};
                4'd4:    cmd = 8'h6D;
                4'd5:    cmd = 8'h70 | {4'd0, contrast[3:0]};
                4'd6:    cmd = 8'h38;
                4'd7:    cmd = 8'h0C;
                4'd8:    cmd = 8'h01;
                default: cmd = 8'h06;
            endcase
            return cmd;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/lcdseq_engine.sv
`default_nettype none

module lcdseq_engine #(
    parameter int TIMEOUT_POLLS = lcdseq_pkg::TIMEOUT_POLLS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire lcdseq_pkg::item_t   item,
    input  wire logic [5:0]          contrast,
    output lcdseq_pkg::result_t      res_a,
    output lcdseq_pkg::result_t      res_b,
    output logic                     two_results
);

    localparam logic [7:0] POLL_LIMIT = 8'(TIMEOUT_POLLS);

    logic       display_on_reg,   display_on_next;
    logic       waiting_reg,      waiting_next;
    logic [7:0] pending_byte_reg, pending_byte_next;
    logic       pending_rs_reg,   pending_rs_next;
    logic [3:0] init_step_reg,    init_step_next;
    logic [7:0] poll_count_reg,   poll_count_next;

    lcdseq_pkg::result_t flag_res;
    lcdseq_pkg::result_t busy_res;

    always_comb
    begin
        flag_res = '0;
        busy_res = '0;
        busy_res.op = lcdseq_pkg::OP_BUSY_READ;

        display_on_next   = display_on_reg;
        waiting_next      = waiting_reg;
        pending_byte_next = pending_byte_reg;
        pending_rs_next   = pending_rs_reg;
        init_step_next    = init_step_reg;
        poll_count_next   = poll_count_reg;
        res_a             = '0;
        res_b             = '0;
        two_results       = 1'b0;

        if (item.command == lcdseq_pkg::CMD_POWER_OFF)
        begin
            display_on_next = 1'b0;
            waiting_next    = 1'b0;
            init_step_next  = 4'd0;
            poll_count_next = 8'd0;
            res_a.op        = lcdseq_pkg::OP_ALL_LOW;
        end
        else if (item.command == lcdseq_pkg::CMD_STATUS)
        begin
            if (!waiting_reg)
            begin
                res_a          = flag_res;
                res_a.rejected = 1'b1;
            end
            else if (poll_count_reg < POLL_LIMIT && item.value[7])
            begin
                // Still busy: poll again
                poll_count_next = poll_count_reg + 8'd1;
                res_a           = busy_res;
            end
            else
            begin
                if (!item.value[7])
                begin
                    res_a.op         = lcdseq_pkg::OP_WRITE;
                    res_a.reg_select = pending_rs_reg;
                    res_a.bus_data   = pending_byte_reg;
                end
                else
                begin
                    res_a           = flag_res;
                    res_a.timed_out = 1'b1;
                end
                // Write done or dropped: advance init if one is running
                waiting_next    = 1'b0;
                poll_count_next = 8'd0;
                if (init_step_reg != 4'd0)
                begin
                    if (init_step_reg >= lcdseq_pkg::INIT_LEN)
                    begin
                        init_step_next  = 4'd0;
                        display_on_next = 1'b1;
                    end
                    else
                    begin
                        init_step_next    = init_step_reg + 4'd1;
                        pending_byte_next = lcdseq_pkg::init_cmd(init_step_reg + 4'd1, contrast);
                        pending_rs_next   = 1'b0;
                        waiting_next      = 1'b1;
                        poll_count_next   = 8'd1;
                        res_b             = busy_res;
                        two_results       = 1'b1;
                    end
                end
            end
        end
        else if (item.command > lcdseq_pkg::CMD_STATUS || waiting_reg ||
                 (item.command != lcdseq_pkg::CMD_POWER_ON && !display_on_reg))
        begin
            res_a          = flag_res;
            res_a.rejected = 1'b1;
        end
        else
        begin
            waiting_next    = 1'b1;
            poll_count_next = 8'd1;
            pending_rs_next = 1'b0;
            if (item.command == lcdseq_pkg::CMD_POWER_ON)
            begin
                res_a.op          = lcdseq_pkg::OP_POWER_ON;
                res_b             = busy_res;
                two_results       = 1'b1;
                init_step_next    = 4'd1;
                pending_byte_next = lcdseq_pkg::init_cmd(4'd1, contrast);
            end
            else
            begin
                res_a = busy_res;
                if (item.command == lcdseq_pkg::CMD_GOTO)
                begin
                    pending_byte_next = {1'b1, item.row, 2'b00, item.column};
                end
                else
                begin
                    pending_byte_next = item.value;
                    pending_rs_next   = (item.command == lcdseq_pkg::CMD_WRITE_DAT);
                end
            end
        end

        if (two_results)
        begin
            res_b.last = 1'b1;
        end
        else
        begin
            res_a.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_on_reg   <= 1'b0;
            waiting_reg      <= 1'b0;
            pending_byte_reg <= 8'd0;
            pending_rs_reg   <= 1'b0;
            init_step_reg    <= 4'd0;
            poll_count_reg   <= 8'd0;
        end
        else if (fire)
        begin
            display_on_reg   <= display_on_next;
            waiting_reg      <= waiting_next;
            pending_byte_reg <= pending_byte_next;
            pending_rs_reg   <= pending_rs_next;
            init_step_reg    <= init_step_next;
            poll_count_reg   <= poll_count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/char_lcd_bus_sequencer_top.sv
// Host-side sequencer for an 8-bit character LCD bus. Each request beat on the
// slave side (power on, power off, write command, write data, goto, or a busy
// status byte read back from the module) yields one or two result beats on the
// master side, tlast marking the final one. Every write is preceded by a busy
// read; the write goes out when a status beat arrives with bit 7 clear, and is
// dropped with timed_out after TIMEOUT_POLLS busy reads. Power on emits the
// power-pin beat followed by a nine-command init whose contrast bits come from
// the contrast register (writes clamped to 20..63). Rate: a request is taken
// every cycle as long as the master side keeps up; the limit is the output
// side's one beat per cycle, so a request that yields two beats (power on, or a
// status beat that completes an init write) can stall the input. A request
// beat passes through the input register and then the four-entry result queue
// before its first result beat appears.

`default_nettype none

module char_lcd_bus_sequencer_top #(
    parameter int TIMEOUT_POLLS = lcdseq_pkg::TIMEOUT_POLLS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Contrast write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [5:0]                          cfg_data,

    // Request beats
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // command[2:0], value[10:3], column[14:11], row[15]
    input  wire logic [lcdseq_pkg::TDATA_IN_W-1:0]   s_tdata,

    // Result beats
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // op[1:0], reg_select[2], bus_data[10:3], zero[15:11]
    output logic [lcdseq_pkg::TDATA_OUT_W-1:0]       m_tdata,
    // timed_out[0], rejected[1]
    output logic [lcdseq_pkg::TUSER_OUT_W-1:0]       m_tuser,
    output logic                                     m_tlast
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Contrast register; saturate low values on write
    logic [5:0] contrast_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_reg <= lcdseq_pkg::CONTRAST_RESET;
        end
        else if (cfg_valid)
        begin
            contrast_reg <= (cfg_data < lcdseq_pkg::CONTRAST_MIN) ?
                            lcdseq_pkg::CONTRAST_MIN : cfg_data;
        end
    end

    // Input register
    logic              in_valid_reg;
    lcdseq_pkg::item_t in_item_reg;
    logic              fire;
    logic [QCNT_W-1:0] count_reg;

    // Process only when the queue has room for two beats
    assign fire     = in_valid_reg && (count_reg <= QCNT_W'(QDEPTH - 2));
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.command <= s_tdata[2:0];
            in_item_reg.value   <= s_tdata[10:3];
            in_item_reg.column  <= s_tdata[14:11];
            in_item_reg.row     <= s_tdata[15];
        end
    end

    // Decision logic and sequencer state
    lcdseq_pkg::result_t res_a;
    lcdseq_pkg::result_t res_b;
    logic                two_results;

    lcdseq_engine #(
        .TIMEOUT_POLLS (TIMEOUT_POLLS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (in_item_reg),
        .contrast    (contrast_reg),
        .res_a       (res_a),
        .res_b       (res_b),
        .two_results (two_results)
    );

    // Result queue: push one or two beats, pop one
    lcdseq_pkg::result_t q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   push_n;
    logic                pop;

    assign pop    = m_tvalid && m_tready;
    assign push_n = fire ? (two_results ? QCNT_W'(2) : QCNT_W'(1)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n[QPTR_W-1:0];
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_reg + push_n - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            q_reg[wr_ptr_reg] <= res_a;
            if (two_results)
            begin
                q_reg[wr_ptr_reg + QPTR_W'(1)] <= res_b;
            end
        end
    end

    lcdseq_pkg::result_t head;

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {5'd0, head.bus_data, head.reg_select, head.op};
    assign m_tuser  = {head.rejected, head.timed_out};
    assign m_tlast  = head.last;

endmodule

`default_nettype wire
